>>> src/otwpd_pkg.sv
// ----------------------------------------------------------------------------
// otwpd_pkg: shared types and constants of the omni base tracker
// Fixed-point formats, controller commands, status and helper functions.
// ----------------------------------------------------------------------------
package otwpd_pkg;

	// Fractional bits of every pose, gain and wheel quantity.
	localparam int FRAC_BITS = 16;
	// Fractional bits of sine, cosine and sqrt(3)/2.
	localparam int TRIG_FRAC = 30;
	localparam int ANG_SHIFT = TRIG_FRAC - FRAC_BITS;

	// Accumulator width, enough for the sum of two 33 x 33 products.
	localparam int ACC_W = 67;
	// Dividend width of the velocity divider: 33-bit difference scaled up.
	localparam int DIV_W = 33 + FRAC_BITS;
	localparam int ATAN_ENTRIES = 24;

	typedef logic signed [ACC_W-1:0] acc_t;

	// CORDIC angle constants with TRIG_FRAC fractional bits.
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [32:0] CORDIC_K    = 33'sd652032874;
	localparam logic signed [32:0] SQRT3_HALF  = 33'sd929887697;

	// Pi rounded to FRAC_BITS fractional bits, for the heading error wrap.
	localparam logic signed [19:0] PI_Q =
		20'((64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS))) >>> ANG_SHIFT);
	localparam logic signed [19:0] TWO_PI_Q = 20'(2 * PI_Q);

	// Configuration register indexes.
	localparam logic [1:0] CFG_PROP  = 2'd0;
	localparam logic [1:0] CFG_DERIV = 2'd1;
	localparam logic [1:0] CFG_ARM   = 2'd2;

	localparam logic [23:0] PROP_RESET  = 24'd4587520;
	localparam logic [23:0] DERIV_RESET = 24'd26214;
	localparam logic [15:0] ARM_RESET   = 16'd8520;

	// Multiply operations issued to the shared multiplier.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PX,
		OP_DX,
		OP_PY,
		OP_DY,
		OP_PT,
		OP_CUX,
		OP_SUY,
		OP_CUY,
		OP_SUX,
		OP_ARM,
		OP_CROSS
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVX_GO,
		S_DIVX_RUN,
		S_DIVY_GO,
		S_DIVY_RUN,
		S_TRIG_WAIT,
		S_MUL,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_axis;
		op_t  mul_op;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic cordic_busy;
	} status_t;

	function automatic logic signed [31:0] sat32(input acc_t v);
		logic [ACC_W-32:0] top;
		top = v[ACC_W-1:31];
		if (top == '0 || top == '1) begin
			return v[31:0];
		end
		return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0:    return 35'sd843314857;
			5'd1:    return 35'sd497837830;
			5'd2:    return 35'sd263043837;
			5'd3:    return 35'sd133525159;
			5'd4:    return 35'sd67021687;
			5'd5:    return 35'sd33543515;
			5'd6:    return 35'sd16775851;
			5'd7:    return 35'sd8388438;
			5'd8:    return 35'sd4194283;
			5'd9:    return 35'sd2097149;
			5'd10:   return 35'sd1048576;
			5'd11:   return 35'sd524288;
			5'd12:   return 35'sd262144;
			5'd13:   return 35'sd131072;
			5'd14:   return 35'sd65536;
			5'd15:   return 35'sd32768;
			5'd16:   return 35'sd16384;
			5'd17:   return 35'sd8192;
			5'd18:   return 35'sd4096;
			5'd19:   return 35'sd2048;
			5'd20:   return 35'sd1024;
			5'd21:   return 35'sd512;
			5'd22:   return 35'sd256;
			5'd23:   return 35'sd128;
			default: return 35'sd0;
		endcase
	endfunction

endpackage

>>> src/otwpd_div.sv
// ----------------------------------------------------------------------------
// otwpd_div: restoring divider, one quotient bit per cycle
// Divides an unsigned scaled difference by the sample interval.
// ----------------------------------------------------------------------------
module otwpd_div
	import otwpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [16:0]      divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dq_q;
	logic [16:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [17:0]      trial;
	logic             fits;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 17'(trial - {1'b0, divisor}) : trial[16:0];
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

>>> src/otwpd_cordic.sv
// ----------------------------------------------------------------------------
// otwpd_cordic: iterative rotation-mode CORDIC for sine and cosine
// One micro-rotation per cycle after a quadrant fold of the heading.
// ----------------------------------------------------------------------------
module otwpd_cordic
	import otwpd_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [18:0] heading,
	output logic               busy,
	output logic signed [32:0] cos_o,
	output logic signed [32:0] sin_o
);

	localparam int CW = $clog2(STEPS + 1);

	logic signed [34:0] a_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic               flip_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;

	logic signed [34:0] a0;
	logic signed [34:0] a1;
	logic signed [34:0] a2;
	logic               flip;
	logic signed [32:0] shx;
	logic signed [32:0] shy;
	logic signed [34:0] step_ang;

	// Bring the angle into plus/minus pi, then fold it into plus/minus pi/2.
	always_comb begin
		a0   = 35'(heading) <<< ANG_SHIFT;
		a1   = a0;
		if (a0 > PI_Q30) begin
			a1 = a0 - TWO_PI_Q30;
		end else if (a0 < -PI_Q30) begin
			a1 = a0 + TWO_PI_Q30;
		end
		a2   = a1;
		flip = 1'b0;
		if (a1 > HALF_PI_Q30) begin
			a2   = a1 - PI_Q30;
			flip = 1'b1;
		end else if (a1 < -HALF_PI_Q30) begin
			a2   = a1 + PI_Q30;
			flip = 1'b1;
		end
	end

	assign shx      = x_q >>> cnt_q;
	assign shy      = y_q >>> cnt_q;
	assign step_ang = atan_q30(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a2;
			x_q    <= CORDIC_K;
			y_q    <= '0;
			flip_q <= flip;
		end else if (busy_q) begin
			if (a_q >= 0) begin
				x_q <= x_q - shy;
				y_q <= y_q + shx;
				a_q <= a_q - step_ang;
			end else begin
				x_q <= x_q + shy;
				y_q <= y_q - shx;
				a_q <= a_q + step_ang;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule

>>> src/otwpd_datapath.sv
// ----------------------------------------------------------------------------
// otwpd_datapath: operand registers, shared multiplier and accumulator
// Holds the item, the previous pose, configuration and the wheel outputs.
// ----------------------------------------------------------------------------
module otwpd_datapath
	import otwpd_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [18:0] heading,
	input  logic [16:0]        interval,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic signed [18:0] goal_heading,
	input  logic signed [31:0] goal_vel_x,
	input  logic signed [31:0] goal_vel_y,
	input  logic signed [31:0] goal_acc_x,
	input  logic signed [31:0] goal_acc_y,
	output logic signed [31:0] wheel_left,
	output logic signed [31:0] wheel_back,
	output logic signed [31:0] wheel_right
);

	logic [23:0] prop_q;
	logic [23:0] deriv_q;
	logic [15:0] arm_q;

	logic signed [31:0] last_x_q;
	logic signed [31:0] last_y_q;

	logic signed [32:0] diff_x_q;
	logic signed [32:0] diff_y_q;
	logic signed [32:0] ex_q;
	logic signed [32:0] ey_q;
	logic signed [19:0] eh_q;
	logic signed [31:0] gvx_q;
	logic signed [31:0] gvy_q;
	logic signed [31:0] gax_q;
	logic signed [31:0] gay_q;
	logic [16:0]        ivl_q;
	logic               axis_q;

	logic signed [31:0] vel_x_q;
	logic signed [31:0] vel_y_q;
	logic signed [31:0] ux_q;
	logic signed [31:0] uy_q;
	logic signed [31:0] ut_q;
	logic signed [31:0] vx_q;
	logic signed [31:0] vy_q;
	logic signed [33:0] lu_q;
	logic signed [33:0] cross_q;
	acc_t               acc_q;

	logic signed [65:0] prod_s1;
	op_t                op_s1;

	logic signed [31:0] wl_q;
	logic signed [31:0] wb_q;
	logic signed [31:0] wr_q;

	logic signed [19:0] eh_raw;
	logic signed [19:0] eh_wrap;
	logic signed [32:0] div_diff;
	logic [32:0]        div_mag;
	logic [DIV_W-1:0]   quotient;
	logic               div_done;
	logic signed [32:0] cos_v;
	logic signed [32:0] sin_v;
	logic               cordic_busy;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	acc_t               quo_ext;
	acc_t               vel_full;
	acc_t               pf;
	acc_t               pw;
	acc_t               half;
	acc_t               w_left;
	acc_t               w_back;
	acc_t               w_right;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= PROP_RESET;
			deriv_q <= DERIV_RESET;
			arm_q   <= ARM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROP:  prop_q  <= cfg_data;
				CFG_DERIV: deriv_q <= cfg_data;
				CFG_ARM:   arm_q   <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	// The heading error never lies beyond one turn of plus/minus pi.
	always_comb begin
		eh_raw  = 20'(goal_heading) - 20'(heading);
		eh_wrap = eh_raw;
		if (eh_raw > PI_Q) begin
			eh_wrap = eh_raw - TWO_PI_Q;
		end else if (eh_raw < -PI_Q) begin
			eh_wrap = eh_raw + TWO_PI_Q;
		end
	end

	// Previous pose, the only state carried from item to item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (cmd.capture) begin
			last_x_q <= pos_x;
			last_y_q <= pos_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			diff_x_q <= 33'(pos_x) - 33'(last_x_q);
			diff_y_q <= 33'(pos_y) - 33'(last_y_q);
			ex_q     <= 33'(goal_x) - 33'(pos_x);
			ey_q     <= 33'(goal_y) - 33'(pos_y);
			eh_q     <= eh_wrap;
			gvx_q    <= goal_vel_x;
			gvy_q    <= goal_vel_y;
			gax_q    <= goal_acc_x;
			gay_q    <= goal_acc_y;
			ivl_q    <= (interval == '0) ? 17'd1 : interval;
		end
		if (cmd.div_start) begin
			axis_q <= cmd.div_axis;
		end
	end

	// Velocity by division of the scaled difference magnitude.
	assign div_diff = cmd.div_axis ? diff_y_q : diff_x_q;
	assign div_mag  = div_diff[32] ? 33'(-div_diff) : 33'(div_diff);

	otwpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({div_mag, FRAC_BITS'(0)}),
		.divisor  (ivl_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign quo_ext  = acc_t'({1'b0, quotient});
	assign vel_full = (axis_q ? diff_y_q[32] : diff_x_q[32]) ? -quo_ext : quo_ext;

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (axis_q) begin
				vel_y_q <= sat32(vel_full);
			end else begin
				vel_x_q <= sat32(vel_full);
			end
		end
	end

	otwpd_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.capture),
		.heading (heading),
		.busy    (cordic_busy),
		.cos_o   (cos_v),
		.sin_o   (sin_v)
	);

	assign st.div_done    = div_done;
	assign st.cordic_busy = cordic_busy;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			OP_PX: begin
				mul_a = $signed({9'b0, prop_q});
				mul_b = ex_q;
			end
			OP_DX: begin
				mul_a = $signed({9'b0, deriv_q});
				mul_b = 33'(vel_x_q) - 33'(gvx_q);
			end
			OP_PY: begin
				mul_a = $signed({9'b0, prop_q});
				mul_b = ey_q;
			end
			OP_DY: begin
				mul_a = $signed({9'b0, deriv_q});
				mul_b = 33'(vel_y_q) - 33'(gvy_q);
			end
			OP_PT: begin
				mul_a = $signed({9'b0, prop_q});
				mul_b = 33'(eh_q);
			end
			OP_CUX: begin
				mul_a = cos_v;
				mul_b = 33'(ux_q);
			end
			OP_SUY: begin
				mul_a = sin_v;
				mul_b = 33'(uy_q);
			end
			OP_CUY: begin
				mul_a = cos_v;
				mul_b = 33'(uy_q);
			end
			OP_SUX: begin
				mul_a = sin_v;
				mul_b = 33'(ux_q);
			end
			OP_ARM: begin
				mul_a = $signed({17'b0, arm_q});
				mul_b = 33'(ut_q);
			end
			OP_CROSS: begin
				mul_a = SQRT3_HALF;
				mul_b = 33'(vy_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= cmd.mul_op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign pw = acc_t'(prod_s1);
	assign pf = pw >>> FRAC_BITS;

	// Accumulate stage, fed by the registered product.
	always_ff @(posedge clk) begin
		case (op_s1)
			OP_PX:    acc_q   <= acc_t'(gax_q) + pf;
			OP_DX:    ux_q    <= sat32(acc_q - pf);
			OP_PY:    acc_q   <= acc_t'(gay_q) + pf;
			OP_DY:    uy_q    <= sat32(acc_q - pf);
			OP_PT:    ut_q    <= sat32(pf);
			OP_CUX:   acc_q   <= pw;
			OP_SUY:   vx_q    <= sat32((acc_q + pw) >>> TRIG_FRAC);
			OP_CUY:   acc_q   <= pw;
			OP_SUX:   vy_q    <= sat32((acc_q - pw) >>> TRIG_FRAC);
			OP_ARM:   lu_q    <= pf[33:0];
			OP_CROSS: cross_q <= 34'(pw >>> TRIG_FRAC);
			default:  ;
		endcase
	end

	// Wheel mix for the 120-degree base.
	always_comb begin
		half    = acc_t'(vx_q) >>> 1;
		w_left  = -half - acc_t'(cross_q) + acc_t'(lu_q);
		w_back  = acc_t'(vx_q) + acc_t'(lu_q);
		w_right = -half + acc_t'(cross_q) + acc_t'(lu_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			wl_q <= sat32(w_left);
			wb_q <= sat32(w_back);
			wr_q <= sat32(w_right);
		end
	end

	assign wheel_left  = wl_q;
	assign wheel_back  = wb_q;
	assign wheel_right = wr_q;

endmodule

>>> src/otwpd_ctrl.sv
// ----------------------------------------------------------------------------
// otwpd_ctrl: sequencer of the tracker
// Steps through capture, two divisions, the CORDIC wait, the multiplies and the output write.
// ----------------------------------------------------------------------------
module otwpd_ctrl
	import otwpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t st
);

	localparam logic [3:0] LAST_STEP = 4'd11;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       can_load;

	function automatic op_t step_op(input logic [3:0] step);
		case (step)
			4'd0:    return OP_PX;
			4'd1:    return OP_DX;
			4'd2:    return OP_PY;
			4'd3:    return OP_DY;
			4'd4:    return OP_PT;
			4'd5:    return OP_CUX;
			4'd6:    return OP_SUY;
			4'd7:    return OP_CUY;
			4'd8:    return OP_SUX;
			4'd9:    return OP_ARM;
			4'd10:   return OP_CROSS;
			default: return OP_NONE;
		endcase
	endfunction

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_valid) state_d = S_DIVX_GO;
			S_DIVX_GO:   state_d = S_DIVX_RUN;
			S_DIVX_RUN:  if (st.div_done) state_d = S_DIVY_GO;
			S_DIVY_GO:   state_d = S_DIVY_RUN;
			S_DIVY_RUN:  if (st.div_done) state_d = S_TRIG_WAIT;
			S_TRIG_WAIT: if (!st.cordic_busy) state_d = S_MUL;
			S_MUL:       if (step_q == LAST_STEP) state_d = S_WRITE;
			S_WRITE:     if (can_load) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_op = OP_NONE;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_DIVX_GO: begin
				cmd.div_start = 1'b1;
			end
			S_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_axis  = 1'b1;
			end
			S_DIVY_RUN: begin
				cmd.div_axis = 1'b1;
			end
			S_MUL: begin
				cmd.mul_op = step_op(step_q);
			end
			S_WRITE: begin
				cmd.load_out = can_load;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_div_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == S_DIVX_RUN || state_q == S_DIVY_RUN))
		else $error("divider finished outside a division state");
	a_trig_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> !st.cordic_busy)
		else $error("multiplies started before sine and cosine were ready");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");
`endif

endmodule

>>> src/omni_three_wheel_pd_tracker.sv
// ----------------------------------------------------------------------------
// omni_three_wheel_pd_tracker: PD trajectory tracker for a three-wheel base
// Turns a measured and a goal pose into three saturated wheel speed commands.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_ready  pose, interval, goal pose, velocity, accel
//   out      out_valid/out_ready  wheel_left, wheel_back, wheel_right
//   cfg      cfg_we               cfg_index, cfg_data (prop, deriv, wheel arm)
//
// The block takes no new item until the current one is written to the
// output register. The pace is set by the velocity divider, which retires
// one quotient bit per cycle for 49 bits, once for x and once for y; the
// CORDIC runs alongside the first division and the twelve-step multiply
// sequence on the shared multiplier follows.
// Reset clears the previous pose to zero and loads the default gains.
// A result waits in the output register while the next item is accepted and
// worked on; only its final write stalls until the waiting transfer is taken.
//
module omni_three_wheel_pd_tracker
	import otwpd_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [18:0] heading,
	input  logic [16:0]        interval,
	input  logic signed [31:0] goal_x,
	input  logic signed [31:0] goal_y,
	input  logic signed [18:0] goal_heading,
	input  logic signed [31:0] goal_vel_x,
	input  logic signed [31:0] goal_vel_y,
	input  logic signed [31:0] goal_acc_x,
	input  logic signed [31:0] goal_acc_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] wheel_left,
	output logic signed [31:0] wheel_back,
	output logic signed [31:0] wheel_right
);

	// The controller sees the handshakes and the datapath status and issues
	// commands; all arithmetic and every payload register sit in the datapath.
	cmd_t    cmd;
	status_t st;

	otwpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	// The datapath captures an item on the input transfer, updates the
	// stored pose in the same cycle and delivers the wheel mix into its
	// output register for the output transfer.
	otwpd_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.interval     (interval),
		.goal_x       (goal_x),
		.goal_y       (goal_y),
		.goal_heading (goal_heading),
		.goal_vel_x   (goal_vel_x),
		.goal_vel_y   (goal_vel_y),
		.goal_acc_x   (goal_acc_x),
		.goal_acc_y   (goal_acc_y),
		.wheel_left   (wheel_left),
		.wheel_back   (wheel_back),
		.wheel_right  (wheel_right)
	);

endmodule
